// ===== hw/rtl/two_layer_dense_inference_unit_assert.svh =====
// Assertion macros for the two-layer dense inference unit
`ifndef TWO_LAYER_DENSE_INFERENCE_UNIT_ASSERT_SVH
`define TWO_LAYER_DENSE_INFERENCE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TLD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define TLD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/tld_pkg.sv =====
// Package: sizes, codes and arithmetic helpers for the dense inference unit
`default_nettype none
package tld_pkg;
  localparam int MaxInputs   = 16;
  localparam int MaxHidden   = 16;
  localparam int MaxOutputs  = 8;
  localparam int WeightDepth = 512;
  localparam int WaW = $clog2(WeightDepth);
  localparam int InW = $clog2(MaxInputs);
  localparam int HidW = $clog2(MaxHidden);
  localparam int OutW = $clog2(MaxOutputs);

  localparam logic [2:0] RegInputCount  = 3'd0;
  localparam logic [2:0] RegHiddenCount = 3'd1;
  localparam logic [2:0] RegOutputCount = 3'd2;
  localparam logic [2:0] RegNormMin     = 3'd3;
  localparam logic [2:0] RegNormMax     = 3'd4;

  localparam logic CmdWeight = 1'b0;
  localparam logic CmdSample = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/two_layer_dense_inference_unit.sv =====
// Top level: two-layer dense inference unit around a weight memory
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata={value,weight_index}, tuser=command
// m_axis    out  tvalid/tready         tdata=out_value, tuser=out_index, tlast=last
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A weight write is stored when it is accepted. A sample element is accepted and
// then normalized in the divider; s_axis_tready stays low until that is done. The
// final element then runs one multiply-accumulate a cycle through the weight
// memory port, plus waits on m_axis_tready.
// rst is synchronous and clears the control state; memories are not cleared.
`default_nettype none
module two_layer_dense_inference_unit import tld_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // weight_index[8:0], value[40:9], zero fill
  input  wire logic        s_axis_tuser,  // command
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // out_value[31:0]
  output      logic [2:0]  m_axis_tuser,  // out_index[2:0]
  output      logic        m_axis_tlast,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  `include "two_layer_dense_inference_unit_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001, S_DIV  = 10'b0000000010, S_HSET = 10'b0000000100,
    S_HMAC  = 10'b0000001000, S_HEND = 10'b0000010000, S_OSET = 10'b0000100000,
    S_OMAC  = 10'b0001000000, S_DEN  = 10'b0010000000, S_EMIT = 10'b0100000000,
    S_SCALE = 10'b1000000000
  } state_t;

  state_t state;
  logic [4:0] input_count, hidden_count;
  logic [3:0] output_count;
  logic signed [15:0] norm_min, norm_max;

  logic [31:0] wmem [WeightDepth];
  logic [31:0] wrd;
  logic [WaW-1:0] raddr;
  logic [31:0] imem [MaxInputs];
  logic [31:0] hmem [MaxHidden];
  logic [31:0] ird, hrd;

  logic [4:0] ecount;
  logic [4:0] n_in, n_hid;
  logic [3:0] n_out;
  logic signed [16:0] range;

  // restoring divider
  logic [47:0] dq;
  logic [17:0] drem;
  logic [5:0]  dstep;
  logic        dneg;
  logic [16:0] dden;

  logic [4:0] j;        // inner index
  logic [4:0] nidx;     // neuron index
  logic [WaW-1:0] base;
  logic       mval;     // memory data valid
  logic       mval2;    // product valid
  logic [4:0] jd;       // j aligned with memory data
  logic [4:0] jd2;      // j aligned with product
  logic       busy;
  logic signed [63:0] prod;
  logic [31:0] wdel;    // weight aligned with product
  logic signed [55:0] acc;
  logic signed [31:0] osat;
  logic signed [49:0] den;
  logic [31:0] res;
  logic [2:0]  res_idx;
  logic        res_last;

  logic in_acc;
  logic [4:0] inlim;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = (state == S_EMIT);
  assign m_axis_tdata = res;
  assign m_axis_tuser = res_idx;
  assign m_axis_tlast = res_last;

  assign n_in  = (input_count == 5'd0) ? 5'd1 :
                 (input_count > 5'(MaxInputs)) ? 5'(MaxInputs) : input_count;
  assign n_hid = (hidden_count == 5'd0) ? 5'd1 :
                 (hidden_count > 5'(MaxHidden)) ? 5'(MaxHidden) : hidden_count;
  assign n_out = (output_count == 4'd0) ? 4'd1 :
                 (output_count > 4'(MaxOutputs)) ? 4'(MaxOutputs) : output_count;
  assign range = 17'(norm_max) - 17'(norm_min);
  assign inlim = (state == S_HMAC || state == S_HSET) ? n_in : n_hid;

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegInputCount:  input_count  <= cfg_data[4:0];
        RegHiddenCount: hidden_count <= cfg_data[4:0];
        RegOutputCount: output_count <= cfg_data[3:0];
        RegNormMin:     norm_min     <= cfg_data;
        RegNormMax:     norm_max     <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      input_count <= 5'd4; hidden_count <= 5'd4; output_count <= 4'd1;
      norm_min <= 16'sd0; norm_max <= 16'sd1000;
    end
  end

  // weight memory: one write port from the stream, one registered read
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == CmdWeight)
      wmem[s_axis_tdata[WaW-1:0]] <= s_axis_tdata[40:9];
    wrd <= wmem[raddr];
    ird <= imem[j[InW-1:0]];
    hrd <= hmem[j[HidW-1:0]];
  end

  always_comb raddr = base + WaW'(j);

  logic signed [31:0] opnd;
  always_comb opnd = (state == S_HMAC || state == S_HEND) ? ird : hrd;

  always_ff @(posedge clk) begin
    prod <= $signed(opnd) * $signed(wrd);
    wdel <= wrd;
    if (state == S_DIV) begin
      if (dstep != 6'd48) begin
        logic [17:0] t;
        t = {drem[16:0], dq[47]} - {1'b0, dden};
        if (!t[17]) begin drem <= t; dq <= {dq[46:0], 1'b1}; end
        else begin drem <= {drem[16:0], dq[47]}; dq <= {dq[46:0], 1'b0}; end
        dstep <= dstep + 6'd1;
      end
    end
    if (in_acc && s_axis_tuser == CmdSample) begin
      logic signed [48:0] num;
      num = 49'($signed(s_axis_tdata[40:9])) - (49'(norm_min) <<< 16);
      dneg <= num[48];
      dq <= num[48] ? 48'(-num) : num[47:0];
      drem <= 18'd0;
      dstep <= 6'd0;
      dden <= range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ecount <= 5'd0; mval <= 1'b0; mval2 <= 1'b0; busy <= 1'b0;
    end else begin
      mval <= busy;
      mval2 <= mval;
      jd <= j;
      jd2 <= jd;
      case (state)
        S_IDLE: if (in_acc && s_axis_tuser == CmdSample) state <= S_DIV;
        S_DIV: if (dstep == 6'd48) begin
          logic signed [48:0] qv;
          qv = dneg ? -49'(dq) : 49'(dq);
          imem[ecount[InW-1:0]] <= (range > 17'sd0) ? sat32(64'(qv)) : 32'd0;
          if (ecount + 5'd1 >= n_in) begin
            ecount <= 5'd0; nidx <= 5'd0; base <= '0; state <= S_HSET;
          end else begin
            ecount <= ecount + 5'd1; state <= S_IDLE;
          end
        end
        S_HSET, S_OSET: begin
          j <= 5'd0; acc <= '0; busy <= 1'b1;
          state <= (state == S_HSET) ? S_HMAC : S_OMAC;
        end
        S_HMAC, S_OMAC: begin
          // issue read j; the weight is registered into wrd, the product into prod, then accumulated
          if (busy) begin
            if (j == inlim) busy <= 1'b0; else j <= j + 5'd1;
          end
          if (mval2) begin
            if (jd2 == inlim) begin
              acc <= acc + 56'($signed(wdel));
              state <= (state == S_HMAC) ? S_HEND : S_DEN;
            end else acc <= acc + 56'(prod >>> 16);
          end
        end
        S_HEND: begin
          hmem[nidx[HidW-1:0]] <= sat32(64'(acc));
          base <= base + WaW'(n_in) + WaW'(1);
          if (nidx + 5'd1 == n_hid) begin nidx <= 5'd0; state <= S_OSET; end
          else begin nidx <= nidx + 5'd1; state <= S_HSET; end
        end
        S_DEN: begin
          osat <= sat32(64'(acc));
          res_idx <= nidx[2:0];
          res_last <= (nidx + 5'd1 == 5'(n_out));
          state <= S_SCALE;
        end
        // denormalise: product registered into den, saturated into res
        S_SCALE: begin
          den <= 50'(osat) * 50'(range) + (50'(norm_min) <<< 16);
          state <= S_EMIT;
        end
        S_EMIT: if (m_axis_tready) begin
          base <= base + WaW'(n_hid) + WaW'(1);
          if (res_last) state <= S_IDLE;
          else begin nidx <= nidx + 5'd1; state <= S_OSET; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb res = sat32(64'(den));

  `TLD_ASSERT_IMP(a_ready_idle, s_axis_tready, state == S_IDLE)
  `TLD_ASSERT_NEXT(a_emit_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `TLD_ASSERT_IMP(a_ecount_rng, 1'b1, ecount < 5'(MaxInputs))
  `TLD_ASSERT_IMP(a_emit_idx, m_axis_tvalid, res_idx < 3'(n_out) || n_out == 4'd8)
endmodule
`default_nettype wire
